/* hdl/pidbc_pkg.sv */
// ----------------------------------------------------------------------------
// pidbc_pkg: shared types, constants and microcode for the PID controller
// Payload structs, saturation and clamp helpers, and the control store that
// sequences the datapath of pid_backcalc_antiwindup_top.
// ----------------------------------------------------------------------------
package pidbc_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int DT_W      = 16;
   localparam int DT_FRAC   = 16;
   localparam int GAIN_W    = 31;
   localparam int WIDE_W    = 64;
   localparam int ERR_W     = DATA_W + 2;
   localparam int RAW_W     = DATA_W + 2;
   localparam int DIV_W     = DATA_W + 1 + DT_FRAC;
   localparam int CNT_W     = $clog2(DIV_W + 1);
   localparam int STEP_W    = 4;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [DATA_W-1:0] val_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam val_type VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam val_type VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // half and full turn in the value format
   localparam logic signed [ERR_W-1:0] HALF_TURN = ERR_W'(180 * (1 << FRAC_BITS));
   localparam logic signed [ERR_W-1:0] FULL_TURN = ERR_W'(360 * (1 << FRAC_BITS));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_GAIN_TRACK = 3'd3,
      CSR_OUT_MIN    = 3'd4,
      CSR_OUT_MAX    = 3'd5,
      CSR_WRAP_ANGLE = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] measured;
      logic [DT_W-1:0]          step_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     saturated;
   } rsp_payload_type;

   // ---- microcode ----
   typedef enum logic [1:0] {MA_ERR, MA_WE, MA_ACC, MA_DERIV} mul_a_type;
   typedef enum logic [2:0] {MB_GP, MB_GI, MB_GT, MB_GD, MB_DT} mul_b_type;
   typedef enum logic [2:0] {
      WB_NONE, WB_P, WB_ACC, WB_ACC_ADD, WB_INTEG, WB_D
   } wb_type;
   typedef enum logic [1:0] {ALU_NONE, ALU_ERR, ALU_RAW, ALU_OUT} alu_type;
   typedef enum logic [1:0] {CND_NONE, CND_REQ, CND_DIV, CND_OUT} cond_type;

   typedef struct packed {
      logic              mul_en;
      mul_a_type         mul_a;
      mul_b_type         mul_b;
      wb_type            wb;
      alu_type           alu;
      cond_type          cond;
      logic [STEP_W-1:0] nxt;
   } ctrl_word_type;

   localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
   localparam logic [STEP_W-1:0] S_ERR      = 4'd1;
   localparam logic [STEP_W-1:0] S_MUL_P    = 4'd2;
   localparam logic [STEP_W-1:0] S_MUL_I    = 4'd3;
   localparam logic [STEP_W-1:0] S_MUL_T    = 4'd4;
   localparam logic [STEP_W-1:0] S_SUM_IT   = 4'd5;
   localparam logic [STEP_W-1:0] S_MUL_DT   = 4'd6;
   localparam logic [STEP_W-1:0] S_INTEG    = 4'd7;
   localparam logic [STEP_W-1:0] S_DIV_WAIT = 4'd8;
   localparam logic [STEP_W-1:0] S_MUL_D    = 4'd9;
   localparam logic [STEP_W-1:0] S_WB_D     = 4'd10;
   localparam logic [STEP_W-1:0] S_RAW      = 4'd11;
   localparam logic [STEP_W-1:0] S_OUT      = 4'd12;

   // control store: a product written in one step is written back in the next
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw.mul_en = 1'b0;
      cw.mul_a  = MA_ERR;
      cw.mul_b  = MB_GP;
      cw.wb     = WB_NONE;
      cw.alu    = ALU_NONE;
      cw.cond   = CND_NONE;
      cw.nxt    = step + 4'd1;
      unique case (step)
         S_IDLE:     cw.cond = CND_REQ;
         S_ERR:      cw.alu  = ALU_ERR;
         S_MUL_P:    cw.mul_en = 1'b1;
         S_MUL_I: begin
            cw.wb     = WB_P;
            cw.mul_en = 1'b1;
            cw.mul_b  = MB_GI;
         end
         S_MUL_T: begin
            cw.wb     = WB_ACC;
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_WE;
            cw.mul_b  = MB_GT;
         end
         S_SUM_IT:   cw.wb = WB_ACC_ADD;
         S_MUL_DT: begin
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_ACC;
            cw.mul_b  = MB_DT;
         end
         S_INTEG:    cw.wb = WB_INTEG;
         S_DIV_WAIT: cw.cond = CND_DIV;
         S_MUL_D: begin
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_DERIV;
            cw.mul_b  = MB_GD;
         end
         S_WB_D:     cw.wb = WB_D;
         S_RAW:      cw.alu = ALU_RAW;
         S_OUT: begin
            cw.alu  = ALU_OUT;
            cw.cond = CND_OUT;
            cw.nxt  = S_IDLE;
         end
         default:    cw.nxt = S_IDLE;
      endcase
      return cw;
   endfunction

   function automatic val_type sat_val(input wide_type x);
      val_type r;
      if (x > WIDE_W'(VAL_MAX))      r = VAL_MAX;
      else if (x < WIDE_W'(VAL_MIN)) r = VAL_MIN;
      else                           r = x[DATA_W-1:0];
      return r;
   endfunction

   // lower limit checked first: with inverted limits, values below it give the lower limit, others the upper
   function automatic val_type clamp_val(input wide_type x, input val_type lo,
                                         input val_type hi);
      val_type r;
      if (x < WIDE_W'(lo))      r = lo;
      else if (x > WIDE_W'(hi)) r = hi;
      else                      r = x[DATA_W-1:0];
      return r;
   endfunction

endpackage

/* hdl/pid_backcalc_antiwindup_top.sv */
// ----------------------------------------------------------------------------
// pid_backcalc_antiwindup_top: Q16.16 PID controller with back-calculation
// Microcoded datapath: one shared multiplier, saturating adders and clamps and
// an iterative divider for the derivative, stepped by a small control store.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one item (setpoint, measured, step_time) with valid/ready.
//    req_ready is high only while the sequencer sits in its idle step.
//  - rsp_* returns one item (drive, saturated) per input item, valid/ready.
//    The result sits in an output register, so the next request is taken
//    while an earlier result still waits for rsp_ready.
//  - csr_we/csr_index/csr_wdata write the gains, limits and the angle-wrap
//    flag; write them only while the block is idle.
// Sequence: from acceptance to rsp_valid, one step for the error and the
//  divider start, the bit-serial divide of the measurement change by
//  step_time (the P, I and tracking multiplies run under it), then steps
//  for the derivative multiply, final sum and output register.
//  The next item is taken only after the sequencer returns to its idle step.
// Reset: gains cleared, limits opened to full range, wrap off, integral,
//  last measurement and windup excess cleared. No result pending.
// Stall: if rsp_ready stays low, the block finishes the next item and then
//  holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module pid_backcalc_antiwindup_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pidbc_pkg::req_payload_type             req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pidbc_pkg::rsp_payload_type             rsp_payload,
   input  logic                                   csr_we,
   input  logic [pidbc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pidbc_pkg::DATA_W-1:0]           csr_wdata
);

   // configuration registers
   logic [pidbc_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff, gain_track_ff;
   pidbc_pkg::val_type           out_min_ff, out_max_ff;
   logic                         wrap_ff;

   // sequencer
   logic [pidbc_pkg::STEP_W-1:0] step_ff, step_in;
   pidbc_pkg::ctrl_word_type     cw;
   logic                         hold;
   logic                         req_fire;

   // datapath registers
   pidbc_pkg::val_type             sp_ff, ms_ff;
   logic [pidbc_pkg::DT_W-1:0]     dt_ff;
   pidbc_pkg::val_type             err_ff, err_in;
   pidbc_pkg::val_type             acc_ff, p_ff, d_ff;
   pidbc_pkg::val_type             integ_ff, last_ff, we_ff, we_in;
   logic signed [pidbc_pkg::RAW_W-1:0] raw_ff, raw_in;
   pidbc_pkg::wide_type            prod_ff, prod_in;
   logic                           rsp_valid_ff;
   pidbc_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   // multiplier operands and shared results
   pidbc_pkg::val_type             mul_a;
   logic [pidbc_pkg::GAIN_W-1:0]   mul_b;
   pidbc_pkg::val_type             fm;
   pidbc_pkg::val_type             drv;
   logic signed [pidbc_pkg::ERR_W-1:0] e_raw, e_wrap;

   // divider
   logic                                  div_start;
   logic signed [pidbc_pkg::DATA_W:0]     div_diff;
   logic                                  div_busy;
   pidbc_pkg::val_type                    deriv;

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         gain_track_ff <= '0;
         out_min_ff    <= pidbc_pkg::VAL_MIN;
         out_max_ff    <= pidbc_pkg::VAL_MAX;
         wrap_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pidbc_pkg::CSR_GAIN_P:     gain_p_ff     <= csr_wdata[pidbc_pkg::GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_I:     gain_i_ff     <= csr_wdata[pidbc_pkg::GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_D:     gain_d_ff     <= csr_wdata[pidbc_pkg::GAIN_W-1:0];
            pidbc_pkg::CSR_GAIN_TRACK: gain_track_ff <= csr_wdata[pidbc_pkg::GAIN_W-1:0];
            pidbc_pkg::CSR_OUT_MIN:    out_min_ff    <= csr_wdata;
            pidbc_pkg::CSR_OUT_MAX:    out_max_ff    <= csr_wdata;
            pidbc_pkg::CSR_WRAP_ANGLE: wrap_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- sequencer ----------------
   assign cw        = pidbc_pkg::ucode(step_ff);
   assign req_ready = (cw.cond == pidbc_pkg::CND_REQ);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      unique case (cw.cond)
         pidbc_pkg::CND_REQ:  hold = !req_valid;
         pidbc_pkg::CND_DIV:  hold = div_busy;
         pidbc_pkg::CND_OUT:  hold = rsp_valid_ff && !rsp_ready;
         pidbc_pkg::CND_NONE: hold = 1'b0;
         default:             hold = 1'b0;
      endcase
      step_in = hold ? step_ff : cw.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= pidbc_pkg::S_IDLE;
      else       step_ff <= step_in;
   end

   // ---------------- multiplier ----------------
   always_comb begin
      unique case (cw.mul_a)
         pidbc_pkg::MA_ERR:   mul_a = err_ff;
         pidbc_pkg::MA_WE:    mul_a = we_ff;
         pidbc_pkg::MA_ACC:   mul_a = acc_ff;
         pidbc_pkg::MA_DERIV: mul_a = deriv;
         default:             mul_a = err_ff;
      endcase
      unique case (cw.mul_b)
         pidbc_pkg::MB_GP: mul_b = gain_p_ff;
         pidbc_pkg::MB_GI: mul_b = gain_i_ff;
         pidbc_pkg::MB_GT: mul_b = gain_track_ff;
         pidbc_pkg::MB_GD: mul_b = gain_d_ff;
         pidbc_pkg::MB_DT: mul_b = pidbc_pkg::GAIN_W'(dt_ff);
         default:          mul_b = gain_p_ff;
      endcase
      // signed value times unsigned gain, full 64-bit product
      prod_in = pidbc_pkg::WIDE_W'(mul_a) * pidbc_pkg::WIDE_W'({1'b0, mul_b});
   end

   // Q16.16 and Q0.16 products both drop 16 fraction bits (floor), then saturate
   assign fm = pidbc_pkg::sat_val(prod_ff >>> pidbc_pkg::FRAC_BITS);

   always_ff @(posedge clock) begin
      if (cw.mul_en && !hold) prod_ff <= prod_in;
   end

   // ---------------- error with optional angle wrap ----------------
   always_comb begin
      e_raw  = pidbc_pkg::ERR_W'(sp_ff) - pidbc_pkg::ERR_W'(ms_ff);
      e_wrap = e_raw;
      if (wrap_ff) begin
         if (e_wrap < -pidbc_pkg::HALF_TURN) e_wrap = e_wrap + pidbc_pkg::FULL_TURN;
         if (e_wrap > pidbc_pkg::HALF_TURN)  e_wrap = e_wrap - pidbc_pkg::FULL_TURN;
      end
      err_in = pidbc_pkg::sat_val(pidbc_pkg::WIDE_W'(e_wrap));
   end

   // derivative on measurement: divider takes the change since last item
   assign div_start = (cw.alu == pidbc_pkg::ALU_ERR);
   assign div_diff  = (pidbc_pkg::DATA_W+1)'(ms_ff) - (pidbc_pkg::DATA_W+1)'(last_ff);

   pidbc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (div_diff),
      .divisor (dt_ff),
      .busy    (div_busy),
      .deriv   (deriv)
   );

   // ---------------- final sum, clamp and back-calculation ----------------
   always_comb begin
      raw_in = pidbc_pkg::RAW_W'(p_ff) + pidbc_pkg::RAW_W'(integ_ff)
             + pidbc_pkg::RAW_W'(d_ff);
      drv    = pidbc_pkg::clamp_val(pidbc_pkg::WIDE_W'(raw_ff), out_min_ff, out_max_ff);
      we_in  = pidbc_pkg::sat_val(pidbc_pkg::WIDE_W'(drv) - pidbc_pkg::WIDE_W'(raw_ff));
      rsp_payload_in.drive     = drv;
      rsp_payload_in.saturated = (pidbc_pkg::RAW_W'(drv) != raw_ff);
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sp_ff <= req_payload.setpoint;
         ms_ff <= req_payload.measured;
         // a zero time step counts as one
         dt_ff <= (req_payload.step_time == '0) ? pidbc_pkg::DT_W'(1)
                                                : req_payload.step_time;
      end
      if (!hold) begin
         if (cw.alu == pidbc_pkg::ALU_ERR) err_ff <= err_in;
         if (cw.alu == pidbc_pkg::ALU_RAW) raw_ff <= raw_in;
         if (cw.alu == pidbc_pkg::ALU_OUT) rsp_payload_ff <= rsp_payload_in;
         unique case (cw.wb)
            pidbc_pkg::WB_P:       p_ff   <= fm;
            pidbc_pkg::WB_ACC:     acc_ff <= fm;
            pidbc_pkg::WB_ACC_ADD:
               acc_ff <= pidbc_pkg::sat_val(pidbc_pkg::WIDE_W'(acc_ff)
                                            + pidbc_pkg::WIDE_W'(fm));
            pidbc_pkg::WB_D:       d_ff   <= fm;
            pidbc_pkg::WB_INTEG,
            pidbc_pkg::WB_NONE:    ;
            default:               ;
         endcase
      end
   end

   // controller state: integral, last measurement, windup excess
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         last_ff      <= '0;
         we_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!hold && cw.wb == pidbc_pkg::WB_INTEG) begin
            integ_ff <= pidbc_pkg::clamp_val(
                           pidbc_pkg::WIDE_W'(pidbc_pkg::sat_val(
                              pidbc_pkg::WIDE_W'(integ_ff) + pidbc_pkg::WIDE_W'(fm))),
                           out_min_ff, out_max_ff);
         end
         if (cw.alu == pidbc_pkg::ALU_ERR) last_ff <= ms_ff;
         if (!hold && cw.alu == pidbc_pkg::ALU_OUT) begin
            we_ff        <= we_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hdl/pidbc_div.sv */
// ----------------------------------------------------------------------------
// pidbc_div: derivative divider
// Restoring divide of -(diff << 16) by the time step, one quotient bit per
// cycle, truncating toward zero and saturating to the value range.
// ----------------------------------------------------------------------------
module pidbc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [pidbc_pkg::DATA_W:0]    diff,
   input  logic [pidbc_pkg::DT_W-1:0]           divisor,
   output logic                                 busy,
   output pidbc_pkg::val_type                   deriv
);

   logic                              busy_ff, busy_in;
   logic [pidbc_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [pidbc_pkg::DT_W-1:0]        rem_ff, rem_in;
   logic [pidbc_pkg::DT_W-1:0]        dvs_ff, dvs_in;
   logic [pidbc_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic                              neg_ff, neg_in;
   logic [pidbc_pkg::DATA_W:0]        mag;
   logic [pidbc_pkg::DT_W:0]          trial;
   logic                              ge;

   always_comb begin
      mag     = diff[pidbc_pkg::DATA_W] ? (pidbc_pkg::DATA_W+1)'(-diff)
                                        : (pidbc_pkg::DATA_W+1)'(diff);
      trial   = {rem_ff, quo_ff[pidbc_pkg::DIV_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = pidbc_pkg::CNT_W'(pidbc_pkg::DIV_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = {mag, {pidbc_pkg::DT_FRAC{1'b0}}};
         neg_in  = diff[pidbc_pkg::DATA_W];
      end else if (busy_ff) begin
         rem_in  = ge ? pidbc_pkg::DT_W'(trial - {1'b0, dvs_ff})
                      : trial[pidbc_pkg::DT_W-1:0];
         quo_in  = {quo_ff[pidbc_pkg::DIV_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != pidbc_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // negative diff gives a positive derivative
   always_comb begin
      if (neg_ff) begin
         deriv = (quo_ff > pidbc_pkg::DIV_W'(pidbc_pkg::VAL_MAX))
                 ? pidbc_pkg::VAL_MAX : quo_ff[pidbc_pkg::DATA_W-1:0];
      end else begin
         deriv = (quo_ff > pidbc_pkg::DIV_W'({1'b1, {(pidbc_pkg::DATA_W-1){1'b0}}}))
                 ? pidbc_pkg::VAL_MIN : pidbc_pkg::DATA_W'(-quo_ff);
      end
   end

   assign busy = busy_ff;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: PID controller with back-calculation anti-windup
// Drives setpoint/measurement/time-step items into the controller and checks
// each drive value and saturation flag against a cycle-free Q16.16 predictor.
// A short table of directed rows (register writes, limit and wrap corner cases,
// a few hand-computed results) runs first, then randomized register settings
// with loop-like measurement sequences, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pidbc_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 8;
   localparam int STALL_MAX    = 9;
   localparam int DRAIN_CYCLES = 80;   // longer than one item's latency
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 95;

   localparam logic [DATA_W-1:0] GAIN_FULL = 32'h7FFF_FFFF;

   // one row of the directed table: a register write or an item
   typedef struct {
      bit                is_write;
      csr_idx_type       reg_idx;
      logic [DATA_W-1:0] reg_data;
      req_payload_type   item;
      bit                typed;       // expected result written in by hand
      rsp_payload_type   typed_rsp;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_payload;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   // predictor copy of the registers, at their reset values
   longint kp = 0, ki = 0, kd = 0, kt = 0;
   longint lim_lo = -64'sd2147483648;
   longint lim_hi = 64'sd2147483647;
   bit     wrap_on = 1'b0;
   // predictor copy of the loop state
   longint integ_acc = 0, last_meas = 0, track_excess = 0;

   rsp_payload_type pending_drives[$];
   stim_row_type    stim_rows[$];
   int              mismatch_count = 0;
   bit              send_gaps_on = 1'b1;
   bit              recv_stalls_on = 1'b1;
   val_type         cur_sp = '0, cur_ms = '0;

   pid_backcalc_antiwindup_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint sat32(input longint x);
      longint r;
      if (x > longint'(VAL_MAX))      r = longint'(VAL_MAX);
      else if (x < longint'(VAL_MIN)) r = longint'(VAL_MIN);
      else                            r = x;
      return r;
   endfunction

   // fixed-point product, floor on the shift, then saturate
   function automatic longint fx_mul(input longint a, input longint g, input int sh);
      return sat32((a * g) >>> sh);
   endfunction

   // lower limit checked first: with inverted limits it wins only for values below it
   function automatic longint limit(input longint x);
      longint r;
      if (x < lim_lo)      r = lim_lo;
      else if (x > lim_hi) r = lim_hi;
      else                 r = x;
      return r;
   endfunction

   function automatic void mirror_csr(input csr_idx_type idx, input logic [DATA_W-1:0] d);
      unique case (idx)
         CSR_GAIN_P:     kp = longint'(d[GAIN_W-1:0]);
         CSR_GAIN_I:     ki = longint'(d[GAIN_W-1:0]);
         CSR_GAIN_D:     kd = longint'(d[GAIN_W-1:0]);
         CSR_GAIN_TRACK: kt = longint'(d[GAIN_W-1:0]);
         CSR_OUT_MIN:    lim_lo = longint'($signed(d));
         CSR_OUT_MAX:    lim_hi = longint'($signed(d));
         CSR_WRAP_ANGLE: wrap_on = d[0];
         default: ;
      endcase
   endfunction

   // one control step: updates integral, last measurement and windup excess
   function automatic rsp_payload_type predict_drive(input req_payload_type it);
      longint sp, ms, dt, err, p_term, i_rate, i_new, deriv, d_term, raw, drv;
      rsp_payload_type r;
      sp = longint'($signed(it.setpoint));
      ms = longint'($signed(it.measured));
      dt = (it.step_time == '0) ? 64'sd1 : longint'(it.step_time);

      err = sp - ms;
      if (wrap_on) begin
         if (err < -longint'(HALF_TURN)) err += longint'(FULL_TURN);
         if (err > longint'(HALF_TURN))  err -= longint'(FULL_TURN);
      end
      err = sat32(err);

      p_term = fx_mul(err, kp, FRAC_BITS);

      // back-calculation: the last step's clamp excess feeds the integrator
      i_rate = sat32(fx_mul(err, ki, FRAC_BITS) + fx_mul(track_excess, kt, FRAC_BITS));
      i_rate = fx_mul(i_rate, dt, DT_FRAC);
      i_new = limit(sat32(integ_acc + i_rate));
      integ_acc = i_new;

      // derivative on measurement; division truncates toward zero
      deriv = sat32(-(((ms - last_meas) * (longint'(1) << DT_FRAC)) / dt));
      last_meas = ms;
      d_term = fx_mul(deriv, kd, FRAC_BITS);

      raw = p_term + i_new + d_term;
      drv = limit(raw);
      track_excess = sat32(drv - raw);

      r.drive = drv[DATA_W-1:0];
      r.saturated = (drv != raw);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void add_write(input csr_idx_type idx, input logic [DATA_W-1:0] d);
      stim_row_type row;
      row.is_write = 1'b1;
      row.reg_idx = idx;
      row.reg_data = d;
      row.item = '0;
      row.typed = 1'b0;
      row.typed_rsp = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_item(input val_type sp, input val_type ms,
                                    input logic [DT_W-1:0] dt, input bit typed,
                                    input val_type drv, input logic sat);
      stim_row_type row;
      row.is_write = 1'b0;
      row.reg_idx = CSR_GAIN_P;
      row.reg_data = '0;
      row.item.setpoint = sp;
      row.item.measured = ms;
      row.item.step_time = dt;
      row.typed = typed;
      row.typed_rsp.drive = drv;
      row.typed_rsp.saturated = sat;
      stim_rows.push_back(row);
   endfunction

   // corner values: range ends, zero, one LSB, and the wrap boundaries
   function automatic val_type corner_value();
      val_type v;
      case ($urandom_range(0, 7))
         0: v = VAL_MAX;
         1: v = VAL_MIN;
         2: v = '0;
         3: v = val_type'(HALF_TURN);
         4: v = -val_type'(HALF_TURN);
         5: v = val_type'(HALF_TURN) + 1;
         6: v = -val_type'(HALF_TURN) - 1;
         default: v = 1;
      endcase
      return v;
   endfunction

   // about +-300.0 in Q16.16
   function automatic val_type near_value();
      return val_type'($urandom_range(0, 39321600)) - val_type'(19660800);
   endfunction

   // loop-like sequence: setpoint held in runs, measurement drifting in
   // small steps, with occasional jumps, corners and full-range noise
   function automatic req_payload_type next_item();
      req_payload_type r;
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 2)      cur_sp = corner_value();
      else if (sel < 4) cur_sp = val_type'($urandom);
      else if (sel < 6) cur_sp = near_value();
      sel = $urandom_range(0, 19);
      if (sel < 2)      cur_ms = corner_value();
      else if (sel < 4) cur_ms = val_type'($urandom);
      else if (sel < 7) cur_ms = near_value();
      else              cur_ms = cur_ms + val_type'($urandom_range(0, 32'h0004_0000))
                                        - val_type'(32'h0002_0000);
      sel = $urandom_range(0, 19);
      case (sel)
         0:       r.step_time = '0;
         1:       r.step_time = 16'h0001;
         2:       r.step_time = 16'hFFFF;
         default: r.step_time = (sel < 11) ? DT_W'($urandom_range(1, 2000))
                                           : DT_W'($urandom_range(1, 65535));
      endcase
      r.setpoint = cur_sp;
      r.measured = cur_ms;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_gain();
      logic [DATA_W-1:0] g;
      case ($urandom_range(0, 9))
         0:       g = '0;
         1:       g = GAIN_FULL;
         2:       g = $urandom;                   // top bit is ignored by the block
         default: g = $urandom_range(0, 32'h0004_0000);
      endcase
      return g;
   endfunction

   task automatic csr_write(input csr_idx_type idx, input logic [DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      mirror_csr(idx, d);
   endtask

   // stop sending and wait until every result is back; the block is idle then
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
   endtask

   // settle: hold off until all results are in before the gap starts
   task automatic send_item(input req_payload_type it, input bit typed,
                            input rsp_payload_type typed_rsp, input bit settle);
      int gap;
      rsp_payload_type want;
      gap = send_gaps_on ? $urandom_range(0, STALL_MAX) : 0;
      settle = settle && (pending_drives.size() != 0);
      if (settle || gap != 0) req_valid <= 1'b0;
      if (settle) while (pending_drives.size() != 0) @(posedge clock);
      repeat (gap) @(posedge clock);
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!(req_valid && req_ready === 1'b1));
      want = predict_drive(it);
      if (typed) want = typed_rsp;
      pending_drives.push_back(want);
   endtask

   // ---------------------------------------------------------------- receiver

   // the stall counts from when a result shows up, so it lands on the
   // output hold as well as on idle cycles
   initial begin
      int n;
      rsp_ready <= 1'b0;
      forever begin
         n = recv_stalls_on ? $urandom_range(0, STALL_MAX) : 0;
         if (n == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (rsp_valid !== 1'b1);
            repeat (n - 1) @(posedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            mismatch_count++;
            $error("result with none expected: drive %0d saturated %0d",
                   rsp_payload.drive, rsp_payload.saturated);
         end else begin
            want = pending_drives.pop_front();
            if (rsp_payload.drive !== want.drive) begin
               mismatch_count++;
               $error("drive: expected %0d, actual %0d", want.drive, rsp_payload.drive);
            end
            if (rsp_payload.saturated !== want.saturated) begin
               mismatch_count++;
               $error("saturated: expected %0d, actual %0d",
                      want.saturated, rsp_payload.saturated);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int ph, n;
      logic [DATA_W-1:0] gp, gi, gd, gt, lo, hi, wr, span;
      bit settle;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;

      // reset values: all gains zero, so the drive is zero whatever the error
      add_item(VAL_MAX, VAL_MIN, 16'hFFFF, 1'b1, '0, 1'b0);
      add_item(VAL_MIN, VAL_MAX, 16'h0001, 1'b1, '0, 1'b0);
      // full gains: full-range errors saturate the products; includes a zero time step
      add_write(CSR_GAIN_P, GAIN_FULL);
      add_write(CSR_GAIN_I, 32'hFFFF_FFFF);
      add_write(CSR_GAIN_D, GAIN_FULL);
      add_write(CSR_GAIN_TRACK, 32'h0001_0000);
      add_item(VAL_MAX, VAL_MIN, 16'hFFFF, 1'b0, '0, 1'b0);
      add_item('0, '0, 16'h0000, 1'b0, '0, 1'b0);
      add_item(VAL_MIN, VAL_MAX, 16'h0001, 1'b0, '0, 1'b0);
      add_item(32'h0001_0000, '0, 16'h8000, 1'b0, '0, 1'b0);
      // +-10 limits with a large step: windup, then back-calculation unwinds
      add_write(CSR_GAIN_P, 32'h0002_0000);
      add_write(CSR_GAIN_I, 32'h0001_0000);
      add_write(CSR_GAIN_D, '0);
      add_write(CSR_GAIN_TRACK, 32'h0000_8000);
      add_write(CSR_OUT_MIN, 32'hFFF6_0000);
      add_write(CSR_OUT_MAX, 32'h000A_0000);
      repeat (3) add_item(32'h0064_0000, '0, 16'h1000, 1'b0, '0, 1'b0);
      add_item(32'hFF9C_0000, '0, 16'h1000, 1'b0, '0, 1'b0);
      // angle wrap: +-340 folds, exactly +-180 stays, range ends saturate
      add_write(CSR_GAIN_P, 32'h0001_0000);
      add_write(CSR_GAIN_I, '0);
      add_write(CSR_GAIN_TRACK, '0);
      add_write(CSR_OUT_MIN, VAL_MIN);
      add_write(CSR_OUT_MAX, VAL_MAX);
      add_write(CSR_WRAP_ANGLE, 32'h0000_0001);
      add_item(32'h00AA_0000, 32'hFF56_0000, 16'd1000, 1'b0, '0, 1'b0);
      add_item(32'hFF56_0000, 32'h00AA_0000, 16'd1000, 1'b0, '0, 1'b0);
      add_item(32'h00B4_0000, '0, 16'd1000, 1'b0, '0, 1'b0);
      add_item(32'hFF4C_0000, '0, 16'd1000, 1'b0, '0, 1'b0);
      add_item(VAL_MAX, VAL_MIN, 16'd1000, 1'b0, '0, 1'b0);
      add_item(VAL_MIN, VAL_MAX, 16'd1000, 1'b0, '0, 1'b0);
      // gains off, equal limits: the integral is forced onto the limit
      add_write(CSR_GAIN_P, '0);
      add_write(CSR_WRAP_ANGLE, '0);
      add_write(CSR_OUT_MIN, 32'h0005_0000);
      add_write(CSR_OUT_MAX, 32'h0005_0000);
      add_item('0, '0, 16'd100, 1'b1, 32'h0005_0000, 1'b0);
      add_write(CSR_OUT_MIN, 32'hFFFD_0000);
      add_write(CSR_OUT_MAX, 32'hFFFD_0000);
      add_item('0, '0, 16'd100, 1'b1, 32'hFFFD_0000, 1'b0);
      // inverted limits: integral goes to min, the sum then lands on max
      add_write(CSR_OUT_MIN, 32'h0001_0000);
      add_write(CSR_OUT_MAX, 32'hFFFF_0000);
      add_item('0, '0, 16'd100, 1'b1, 32'hFFFF_0000, 1'b1);
      add_item('0, '0, 16'd100, 1'b0, '0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < stim_rows.size(); i++) begin
         if (stim_rows[i].is_write) begin
            if (i == 0 || !stim_rows[i-1].is_write) drain();
            csr_write(stim_rows[i].reg_idx, stim_rows[i].reg_data);
            if (i + 1 == stim_rows.size() || !stim_rows[i+1].is_write) csr_we <= 1'b0;
         end else begin
            send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].typed_rsp, 1'b0);
         end
      end

      // random phases, each with its own register setting
      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         gp = pick_gain();
         gi = pick_gain();
         gd = pick_gain();
         gt = pick_gain();
         wr = $urandom;
         case ($urandom_range(0, 5))
            0: begin
               lo = VAL_MIN;
               hi = VAL_MAX;
            end
            4: begin
               lo = $urandom;
               hi = lo;
            end
            5: begin
               lo = $urandom;            // inverted about half the time
               hi = $urandom;
            end
            default: begin
               span = $urandom_range(1, 1000) << FRAC_BITS;
               lo = -span;
               hi = span;
            end
         endcase
         if (ph == 0) begin
            gp = GAIN_FULL;
            gi = GAIN_FULL;
            gd = GAIN_FULL;
            gt = GAIN_FULL;
            lo = VAL_MIN;
            hi = VAL_MAX;
         end
         if (ph == 1) begin
            lo = VAL_MIN;
            hi = VAL_MIN;
         end
         if (ph == PHASES - 1) begin
            gp = '0;
            gi = '0;
            gd = '0;
            gt = '0;
            lo = VAL_MAX;
            hi = VAL_MAX;
         end
         csr_write(CSR_GAIN_P, gp);
         csr_write(CSR_GAIN_I, gi);
         csr_write(CSR_GAIN_D, gd);
         csr_write(CSR_GAIN_TRACK, gt);
         csr_write(CSR_OUT_MIN, lo);
         csr_write(CSR_OUT_MAX, hi);
         csr_write(CSR_WRAP_ANGLE, wr);
         csr_we <= 1'b0;

         // some phases run back to back on one or both sides
         send_gaps_on = ($urandom_range(0, 3) != 0);
         recv_stalls_on = ($urandom_range(0, 3) != 0);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            // mid-run pause in one phase for sure, now and then elsewhere
            settle = (ph == 2 && n == PHASE_ITEMS / 2) ||
                     (send_gaps_on && $urandom_range(0, 7) == 0);
            send_item(next_item(), 1'b0, '0, settle);
         end
      end

      drain();
      // anything the block sends after this is a spurious result
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
